[rtl/sha1bs_pkg.sv]
// sha1bs_pkg: shared types, codes and constants for the SHA-1 byte stream hasher
// no dependencies; used by the controller, datapath and top level
`default_nettype none
package sha1bs_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int DIGEST_WORDS = 5;
  localparam int ROUNDS       = 80;

  localparam logic [2:0] LAST_WORD_IDX  = 3'd4;
  localparam logic [6:0] LAST_ROUND     = 7'd79;
  localparam logic [6:0] MSG_ROUNDS     = 7'd16;
  localparam logic [6:0] FN_PAR1_START  = 7'd20;
  localparam logic [6:0] FN_MAJ_START   = 7'd40;
  localparam logic [6:0] FN_PAR2_START  = 7'd60;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] LEN_FILL       = 6'd56;
  localparam logic [2:0] LEN_LAST       = 3'd7;
  localparam logic [7:0] PAD_MARK_BYTE  = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_t;

  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR1,
    FN_MAJ,
    FN_PAR2
  } round_fn_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic [2:0] len_idx;
    logic      count_bits;
    logic      load_work;
    logic      round_en;
    logic      msg_direct;
    round_fn_t round_fn;
    logic      add_hash;
    logic      init;
    logic [2:0] emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_at_len;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/sha1bs_if.sv]
// sha1bs_msg_if and sha1bs_digest_if: valid/ready channels for message and digest beats
// depends on nothing; payload widths follow the field definitions
`default_nettype none
interface sha1bs_msg_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sha1bs_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface
`default_nettype wire

[rtl/sha1_byte_stream_hash.sv]
// sha1_byte_stream_hash: SHA-1 over a byte stream, one message byte per beat
// depends on sha1bs_pkg, sha1bs_if, sha1bs_ctrl and sha1bs_dp
// An absorb beat (op 0) pushes its byte into the block; the 64th byte of a block then holds off
// input while the compression runs one round per cycle through a single round unit (80 rounds)
// and then folds the result into the chaining words. A finish beat (op 1)
// pads the block (0x80, zeros up to byte 56, the 64-bit big-endian bit length),
// runs one or two compressions, and then presents the five digest words, word 0 first, one
// per beat on the digest channel; no new byte is taken until the last word is taken. The
// state then returns to the initial chaining values, ready for the next message.
`default_nettype none
module sha1_byte_stream_hash (
  input  wire logic             clk,
  input  wire logic             rst,
  sha1bs_msg_if.sink            msg,
  sha1bs_digest_if.source       digest
);

  sha1bs_pkg::dp_cmd_t    cmd;
  sha1bs_pkg::dp_status_t status;

  sha1bs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_op      (msg.op),
    .in_ready   (msg.ready),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .word_index (digest.word_index),
    .last_word  (digest.last_word),
    .cmd        (cmd),
    .status     (status)
  );

  sha1bs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .status      (status),
    .digest_word (digest.digest_word)
  );

endmodule
`default_nettype wire

[rtl/sha1bs_ctrl.sv]
// sha1bs_ctrl: controller state machine sequencing absorb, padding, rounds and digest output
// depends on sha1bs_pkg
`default_nettype none
module sha1bs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_op,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 word_index,
  output logic                       last_word,
  output sha1bs_pkg::dp_cmd_t        cmd,
  input  wire sha1bs_pkg::dp_status_t status
);

  sha1bs_pkg::state_t state, state_next;
  sha1bs_pkg::pad_t   pad_phase, pad_phase_next;
  logic [2:0] len_idx, len_idx_next;
  logic [6:0] round_cnt, round_cnt_next;
  logic [2:0] emit_idx, emit_idx_next;
  logic       finishing, finishing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1bs_pkg::S_IDLE;
      pad_phase <= sha1bs_pkg::PAD_MARK;
      len_idx   <= '0;
      round_cnt <= '0;
      emit_idx  <= '0;
      finishing <= 1'b0;
    end else begin
      state     <= state_next;
      pad_phase <= pad_phase_next;
      len_idx   <= len_idx_next;
      round_cnt <= round_cnt_next;
      emit_idx  <= emit_idx_next;
      finishing <= finishing_next;
    end
  end

  // outputs and datapath commands
  always_comb begin
    cmd        = '0;
    cmd.len_idx  = len_idx;
    cmd.emit_idx = emit_idx;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    word_index = emit_idx;
    last_word  = (emit_idx == sha1bs_pkg::LAST_WORD_IDX);
    unique case (state)
      sha1bs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_op == sha1bs_pkg::OP_ABSORB) begin
          cmd.push       = 1'b1;
          cmd.byte_sel   = sha1bs_pkg::SEL_DATA;
          cmd.count_bits = 1'b1;
        end
      end
      sha1bs_pkg::S_PAD: begin
        unique case (pad_phase)
          sha1bs_pkg::PAD_MARK: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sha1bs_pkg::SEL_MARK;
          end
          sha1bs_pkg::PAD_ZERO: begin
            cmd.push     = !status.fill_at_len;
            cmd.byte_sel = sha1bs_pkg::SEL_ZERO;
          end
          sha1bs_pkg::PAD_LEN: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sha1bs_pkg::SEL_LEN;
          end
          sha1bs_pkg::PAD_DONE: begin
            cmd.push = 1'b0;
          end
          default: cmd.push = 1'b0;
        endcase
      end
      sha1bs_pkg::S_ROUND: begin
        cmd.round_en   = 1'b1;
        cmd.msg_direct = (round_cnt < sha1bs_pkg::MSG_ROUNDS);
        priority if (round_cnt < sha1bs_pkg::FN_PAR1_START) cmd.round_fn = sha1bs_pkg::FN_CH;
        else if (round_cnt < sha1bs_pkg::FN_MAJ_START) cmd.round_fn = sha1bs_pkg::FN_PAR1;
        else if (round_cnt < sha1bs_pkg::FN_PAR2_START) cmd.round_fn = sha1bs_pkg::FN_MAJ;
        else cmd.round_fn = sha1bs_pkg::FN_PAR2;
      end
      sha1bs_pkg::S_FINAL: begin
        cmd.add_hash = 1'b1;
      end
      sha1bs_pkg::S_EMIT: begin
        out_valid = 1'b1;
        cmd.init  = out_ready && (emit_idx == sha1bs_pkg::LAST_WORD_IDX);
      end
      default: in_ready = 1'b0;
    endcase
    cmd.load_work = cmd.push && status.fill_full;
  end

  // next state
  always_comb begin
    state_next     = state;
    pad_phase_next = pad_phase;
    len_idx_next   = len_idx;
    round_cnt_next = round_cnt;
    emit_idx_next  = emit_idx;
    finishing_next = finishing;
    unique case (state)
      sha1bs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == sha1bs_pkg::OP_FINISH) begin
            finishing_next = 1'b1;
            pad_phase_next = sha1bs_pkg::PAD_MARK;
            state_next     = sha1bs_pkg::S_PAD;
          end else if (status.fill_full) begin
            round_cnt_next = '0;
            state_next     = sha1bs_pkg::S_ROUND;
          end
        end
      end
      sha1bs_pkg::S_PAD: begin
        unique case (pad_phase)
          sha1bs_pkg::PAD_MARK: pad_phase_next = sha1bs_pkg::PAD_ZERO;
          sha1bs_pkg::PAD_ZERO: begin
            if (status.fill_at_len) begin
              pad_phase_next = sha1bs_pkg::PAD_LEN;
              len_idx_next   = '0;
            end
          end
          sha1bs_pkg::PAD_LEN: begin
            len_idx_next = len_idx + 3'd1;
            if (len_idx == sha1bs_pkg::LEN_LAST) pad_phase_next = sha1bs_pkg::PAD_DONE;
          end
          sha1bs_pkg::PAD_DONE: pad_phase_next = pad_phase;
          default: pad_phase_next = pad_phase;
        endcase
        if (cmd.load_work) begin
          round_cnt_next = '0;
          state_next     = sha1bs_pkg::S_ROUND;
        end
      end
      sha1bs_pkg::S_ROUND: begin
        round_cnt_next = round_cnt + 7'd1;
        if (round_cnt == sha1bs_pkg::LAST_ROUND) state_next = sha1bs_pkg::S_FINAL;
      end
      sha1bs_pkg::S_FINAL: begin
        if (!finishing) begin
          state_next = sha1bs_pkg::S_IDLE;
        end else if (pad_phase == sha1bs_pkg::PAD_DONE) begin
          emit_idx_next = '0;
          state_next    = sha1bs_pkg::S_EMIT;
        end else begin
          state_next = sha1bs_pkg::S_PAD;
        end
      end
      sha1bs_pkg::S_EMIT: begin
        if (out_ready) begin
          if (emit_idx == sha1bs_pkg::LAST_WORD_IDX) begin
            finishing_next = 1'b0;
            state_next     = sha1bs_pkg::S_IDLE;
          end else begin
            emit_idx_next = emit_idx + 3'd1;
          end
        end
      end
      default: state_next = sha1bs_pkg::S_IDLE;
    endcase
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == sha1bs_pkg::S_ROUND) |-> (round_cnt <= sha1bs_pkg::LAST_ROUND))
    else $error("round counter out of range");

  a_final_emit: assert property (@(posedge clk) disable iff (rst)
    (state == sha1bs_pkg::S_FINAL && finishing && pad_phase == sha1bs_pkg::PAD_DONE)
      |=> (state == sha1bs_pkg::S_EMIT && emit_idx == 3'd0))
    else $error("digest output did not follow last compression");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    (state == sha1bs_pkg::S_EMIT) |-> (emit_idx <= sha1bs_pkg::LAST_WORD_IDX))
    else $error("digest word index out of range");

endmodule
`default_nettype wire

[rtl/sha1bs_dp.sv]
// sha1bs_dp: datapath with block shift buffer, rolling schedule, round logic and chaining words
// depends on sha1bs_pkg; driven by sha1bs_ctrl commands
`default_nettype none
module sha1bs_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha1bs_pkg::dp_cmd_t   cmd,
  input  wire logic [7:0]            data_byte,
  output sha1bs_pkg::dp_status_t     status,
  output logic [31:0]                digest_word
);

  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [31:0]  hw [sha1bs_pkg::DIGEST_WORDS];
  logic [31:0]  a, b, c, d, e;

  logic [7:0]  push_byte;
  logic [63:0] len_shifted;
  logic [31:0] sched_x, wr, f, k, t;

  assign status.fill_full   = (fill == sha1bs_pkg::FILL_LAST);
  assign status.fill_at_len = (fill == sha1bs_pkg::LEN_FILL);

  assign len_shifted = bit_count << {cmd.len_idx, 3'b000};

  always_comb begin
    unique case (cmd.byte_sel)
      sha1bs_pkg::SEL_DATA: push_byte = data_byte;
      sha1bs_pkg::SEL_MARK: push_byte = sha1bs_pkg::PAD_MARK_BYTE;
      sha1bs_pkg::SEL_ZERO: push_byte = 8'h00;
      sha1bs_pkg::SEL_LEN:  push_byte = len_shifted[63:56];
      default:              push_byte = 8'h00;
    endcase
  end

  // words 0, 2, 8 and 13 of the window, counted from the oldest
  assign sched_x = blk[511:480] ^ blk[447:416] ^ blk[255:224] ^ blk[95:64];
  assign wr = cmd.msg_direct ? blk[511:480] : {sched_x[30:0], sched_x[31]};

  always_comb begin
    unique case (cmd.round_fn)
      sha1bs_pkg::FN_CH: begin
        f = (b & c) | (~b & d);
        k = sha1bs_pkg::K_CH;
      end
      sha1bs_pkg::FN_PAR1: begin
        f = b ^ c ^ d;
        k = sha1bs_pkg::K_PAR1;
      end
      sha1bs_pkg::FN_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1bs_pkg::K_MAJ;
      end
      sha1bs_pkg::FN_PAR2: begin
        f = b ^ c ^ d;
        k = sha1bs_pkg::K_PAR2;
      end
      default: begin
        f = b ^ c ^ d;
        k = sha1bs_pkg::K_PAR2;
      end
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + wr;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], wr};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= hw[0];
      b <= hw[1];
      c <= hw[2];
      d <= hw[3];
      e <= hw[4];
    end else if (cmd.round_en) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      fill      <= '0;
      bit_count <= '0;
      hw[0]     <= sha1bs_pkg::IV0;
      hw[1]     <= sha1bs_pkg::IV1;
      hw[2]     <= sha1bs_pkg::IV2;
      hw[3]     <= sha1bs_pkg::IV3;
      hw[4]     <= sha1bs_pkg::IV4;
    end else begin
      if (cmd.push) fill <= fill + 6'd1;
      if (cmd.count_bits) bit_count <= bit_count + sha1bs_pkg::BITS_PER_BYTE;
      if (cmd.add_hash) begin
        hw[0] <= hw[0] + a;
        hw[1] <= hw[1] + b;
        hw[2] <= hw[2] + c;
        hw[3] <= hw[3] + d;
        hw[4] <= hw[4] + e;
      end
    end
  end

  always_comb begin
    unique case (cmd.emit_idx)
      3'd0:    digest_word = hw[0];
      3'd1:    digest_word = hw[1];
      3'd2:    digest_word = hw[2];
      3'd3:    digest_word = hw[3];
      3'd4:    digest_word = hw[4];
      default: digest_word = hw[4];
    endcase
  end

  a_fill_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !cmd.init && fill == sha1bs_pkg::FILL_LAST) |=> (fill == 6'd0))
    else $error("buffer fill did not wrap on a full block");

  a_init_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.init |=> (fill == 6'd0 && bit_count == 64'd0 && hw[0] == sha1bs_pkg::IV0))
    else $error("state not restored after digest");

endmodule
`default_nettype wire
